### sv/hpp_pkg.sv
// Shared types, widths and constants for the homogeneous point projection core.
// Depends on nothing; every other file of the block imports it.

package hpp_pkg;

	// Fixed-point formats: Q16.16 inputs, coefficients and results.
	localparam int FRAC      = 16;
	localparam int COEF_W    = 32;
	localparam int Q_W       = 32;
	localparam int CFG_W     = 64;
	localparam int CFG_N     = 6;
	localparam int CFG_IDX_W = 3;
	localparam int ROWS      = 3;

	// A row dot product is four Q32.32 terms summed without loss.
	localparam int DOT_W = 66;
	// Magnitude of a dot product, used as divisor and numerator.
	localparam int DEN_W = DOT_W;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_ROW0_COLS01 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW0_COLS23 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW1_COLS01 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW1_COLS23 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW2_COLS01 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW2_COLS23 = 3'd5;

	// Reset values give u = x, v = y and a depth of one.
	localparam logic [CFG_W-1:0] RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
	localparam logic [CFG_W-1:0] RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW2_COLS23 = 64'h0001_0000_0000_0000;

	// Clamp limits of the quotient magnitude, by sign of the result.
	localparam logic [Q_W-1:0] Q_LIMIT_POS = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] Q_LIMIT_NEG = 32'h8000_0000;

	// One quotient lane as it travels down the divider cells.
	typedef struct packed {
		logic [DEN_W-1:0] rem;  // partial remainder, below the divisor
		logic [Q_W-1:0]   q;    // quotient bits found so far
		logic [Q_W-1:0]   nsh;  // numerator bits still to be shifted in
		logic             neg;  // result is negative
		logic             ovf;  // quotient known not to fit 32 bits
	} hpp_lane_t;

	// Word handed from one divider cell to the next.
	typedef struct packed {
		logic [DEN_W-1:0] den;
		hpp_lane_t        u;
		hpp_lane_t        v;
		logic             dz;
	} hpp_cell_t;

	// Finished result word.
	typedef struct packed {
		logic signed [Q_W-1:0] u;
		logic signed [Q_W-1:0] v;
		logic                  dz;
		logic                  sat;
	} hpp_res_t;

endpackage

### sv/hpp_pnt_if.sv
// Input channel carrying one world point per word.
// Depends on hpp_pkg for the field widths.

interface hpp_pnt_if;
	import hpp_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [COEF_W-1:0] world_x;
	logic signed [COEF_W-1:0] world_y;
	logic signed [COEF_W-1:0] world_z;

	modport source (output valid, output world_x, output world_y, output world_z,
		input ready);
	modport sink (input valid, input world_x, input world_y, input world_z,
		output ready);
endinterface

### sv/hpp_pix_if.sv
// Output channel carrying one projected pixel per word.
// Depends on hpp_pkg for the field widths.

interface hpp_pix_if;
	import hpp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [Q_W-1:0] pixel_u;
	logic signed [Q_W-1:0] pixel_v;
	logic                  depth_zero;
	logic                  saturated;

	modport source (output valid, output pixel_u, output pixel_v, output depth_zero,
		output saturated, input ready);
	modport sink (input valid, input pixel_u, input pixel_v, input depth_zero,
		input saturated, output ready);
endinterface

### sv/hpp_dot.sv
// Two-stage dot product of one matrix row with (x, y, z, 1), kept exact.
// Depends on hpp_pkg.

module hpp_dot (
	input  logic                              clk,
	input  logic                              en,
	input  logic [hpp_pkg::CFG_W-1:0]         coef01,
	input  logic [hpp_pkg::CFG_W-1:0]         coef23,
	input  logic signed [hpp_pkg::COEF_W-1:0] x,
	input  logic signed [hpp_pkg::COEF_W-1:0] y,
	input  logic signed [hpp_pkg::COEF_W-1:0] z,
	output logic signed [hpp_pkg::DOT_W-1:0]  dot
);
	import hpp_pkg::*;

	logic signed [2*COEF_W-1:0]    px_s1;
	logic signed [2*COEF_W-1:0]    py_s1;
	logic signed [2*COEF_W-1:0]    pz_s1;
	logic signed [COEF_W+FRAC-1:0] pw_s1;
	logic signed [DOT_W-1:0]       dot_s2;

	// First stage: three products, and the w term as a plain shift.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed(coef01[COEF_W-1:0]) * x;
			py_s1 <= $signed(coef01[CFG_W-1:COEF_W]) * y;
			pz_s1 <= $signed(coef23[COEF_W-1:0]) * z;
			pw_s1 <= $signed({coef23[CFG_W-1:COEF_W], FRAC'(0)});
		end
	end

	// Second stage: sign-extended sum of the four terms.
	always_ff @(posedge clk) begin
		if (en) begin
			dot_s2 <= DOT_W'(px_s1) + DOT_W'(py_s1) + DOT_W'(pz_s1) + DOT_W'(pw_s1);
		end
	end

	assign dot = dot_s2;
endmodule

### sv/hpp_div_cell.sv
// One restoring-division cell: finds one quotient bit for each of u and v.
// Depends on hpp_pkg for the cell word type.

module hpp_div_cell (
	input  logic               clk,
	input  logic               en,
	input  hpp_pkg::hpp_cell_t cell_in,
	output hpp_pkg::hpp_cell_t cell_out
);
	import hpp_pkg::*;

	hpp_cell_t cell_q;
	hpp_cell_t cell_nx;

	// Shift in the next numerator bit, subtract the divisor when it fits.
	function automatic hpp_lane_t lane_step(hpp_lane_t l, logic [DEN_W-1:0] den);
		logic [DEN_W:0] rsh;
		logic           ge;
		hpp_lane_t      n;
		rsh   = {l.rem, l.nsh[Q_W-1]};
		ge    = (rsh >= {1'b0, den});
		n     = l;
		n.rem = ge ? DEN_W'(rsh - {1'b0, den}) : rsh[DEN_W-1:0];
		n.q   = {l.q[Q_W-2:0], ge};
		n.nsh = {l.nsh[Q_W-2:0], 1'b0};
		return n;
	endfunction

	always_comb begin
		cell_nx   = cell_in;
		cell_nx.u = lane_step(cell_in.u, cell_in.den);
		cell_nx.v = lane_step(cell_in.v, cell_in.den);
	end

	// Hand the word to the next cell.
	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= cell_nx;
		end
	end

	assign cell_out = cell_q;
endmodule

### sv/homogeneous_point_projection_core.sv
// Top level of the pinhole projection core: config registers, dot products,
// divider cell chain and output skid. Depends on hpp_pkg, hpp_pnt_if,
// hpp_pix_if, hpp_dot and hpp_div_cell.
//
//   channel | dir | word                                      | handshake
//   --------+-----+-------------------------------------------+------------
//   pts     | in  | world_x, world_y, world_z (Q16.16)        | valid/ready
//   pix     | out | pixel_u, pixel_v (Q16.16), flags          | valid/ready
//   cfg     | in  | cfg_idx, cfg_data (six 64-bit registers)  | cfg_we only
//
// One point is taken every cycle while the skid register is free. A result
// passes through two stages of dot product (the first loaded at the taking
// edge), sign and overflow preparation over two stages, 32 divider cells
// (one quotient bit each) and the output register.
// Reset clears all valid bits and loads the registers with the identity view.
// A result not taken moves to a skid register; only while that register is
// full does the pipe hold and pts.ready go low.

module homogeneous_point_projection_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hpp_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [hpp_pkg::CFG_W-1:0]          cfg_data,
	hpp_pnt_if.sink                            pts,
	hpp_pix_if.source                          pix
);
	import hpp_pkg::*;

	localparam int NSTG = 4 + Q_W;

	logic [CFG_W-1:0]        cfg_q [CFG_N];
	logic                    en;
	logic [NSTG-1:0]         vld_q;
	logic signed [DOT_W-1:0] dot [ROWS];

	logic [DEN_W-1:0] mag_u_s3;
	logic [DEN_W-1:0] mag_v_s3;
	logic [DEN_W-1:0] mag_d_s3;
	logic             neg_u_s3;
	logic             neg_v_s3;
	logic             dz_s3;
	hpp_cell_t        cell_s4;
	hpp_cell_t        chain [Q_W+1];

	hpp_res_t res;
	hpp_res_t o_q;
	hpp_res_t sk_q;
	logic     o_v_q;
	logic     sk_v_q;

	// Configuration registers; writes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= RST_ROW0_COLS01;
			cfg_q[1] <= RST_ROW0_COLS23;
			cfg_q[2] <= RST_ROW1_COLS01;
			cfg_q[3] <= RST_ROW1_COLS23;
			cfg_q[4] <= RST_ROW2_COLS01;
			cfg_q[5] <= RST_ROW2_COLS23;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_ROW0_COLS01: cfg_q[0] <= cfg_data;
				CFG_ROW0_COLS23: cfg_q[1] <= cfg_data;
				CFG_ROW1_COLS01: cfg_q[2] <= cfg_data;
				CFG_ROW1_COLS23: cfg_q[3] <= cfg_data;
				CFG_ROW2_COLS01: cfg_q[4] <= cfg_data;
				CFG_ROW2_COLS23: cfg_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// The pipe moves whenever the skid register is free.
	assign en        = !sk_v_q;
	assign pts.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], pts.valid};
		end
	end

	// Three row dot products.
	for (genvar r = 0; r < ROWS; r++) begin : g_row
		hpp_dot u_dot (
			.clk    (clk),
			.en     (en),
			.coef01 (cfg_q[2*r]),
			.coef23 (cfg_q[2*r+1]),
			.x      (pts.world_x),
			.y      (pts.world_y),
			.z      (pts.world_z),
			.dot    (dot[r])
		);
	end

	// Split each dot product into sign and magnitude; note a zero depth.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_u_s3 <= dot[0][DOT_W-1] ? DEN_W'(-dot[0]) : DEN_W'(dot[0]);
			mag_v_s3 <= dot[1][DOT_W-1] ? DEN_W'(-dot[1]) : DEN_W'(dot[1]);
			mag_d_s3 <= dot[2][DOT_W-1] ? DEN_W'(-dot[2]) : DEN_W'(dot[2]);
			neg_u_s3 <= dot[0][DOT_W-1] ^ dot[2][DOT_W-1];
			neg_v_s3 <= dot[1][DOT_W-1] ^ dot[2][DOT_W-1];
			dz_s3    <= (dot[2] == '0);
		end
	end

	// Start a lane: the high numerator part is the first remainder, and a
	// quotient of 2^32 or more is caught here by one compare.
	function automatic hpp_lane_t lane_init(logic [DEN_W-1:0] mag, logic [DEN_W-1:0] den,
		logic neg);
		hpp_lane_t l;
		l.rem = mag >> FRAC;
		l.q   = '0;
		l.nsh = {mag[FRAC-1:0], FRAC'(0)};
		l.neg = neg;
		l.ovf = ({FRAC'(0), mag} >= {den, FRAC'(0)});
		return l;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cell_s4.den <= mag_d_s3;
			cell_s4.u   <= lane_init(mag_u_s3, mag_d_s3, neg_u_s3);
			cell_s4.v   <= lane_init(mag_v_s3, mag_d_s3, neg_v_s3);
			cell_s4.dz  <= dz_s3;
		end
	end

	// Divider chain, one quotient bit per cell, most significant first.
	assign chain[0] = cell_s4;
	for (genvar k = 0; k < Q_W; k++) begin : g_cell
		hpp_div_cell u_cell (
			.clk      (clk),
			.en       (en),
			.cell_in  (chain[k]),
			.cell_out (chain[k+1])
		);
	end

	// Clamp to the limit of the result's sign, then apply the sign.
	function automatic logic [Q_W:0] lane_finish(hpp_lane_t l);
		logic [Q_W-1:0] lim;
		logic           sat;
		logic [Q_W-1:0] m;
		lim = l.neg ? Q_LIMIT_NEG : Q_LIMIT_POS;
		sat = l.ovf || (l.q > lim);
		m   = sat ? lim : l.q;
		return {sat, l.neg ? Q_W'(-m) : m};
	endfunction

	always_comb begin
		logic [Q_W:0] fu;
		logic [Q_W:0] fv;
		fu = lane_finish(chain[Q_W].u);
		fv = lane_finish(chain[Q_W].v);
		if (chain[Q_W].dz) begin
			res.u   = '0;
			res.v   = '0;
			res.dz  = 1'b1;
			res.sat = 1'b0;
		end else begin
			res.u   = $signed(fu[Q_W-1:0]);
			res.v   = $signed(fv[Q_W-1:0]);
			res.dz  = 1'b0;
			res.sat = fu[Q_W] | fv[Q_W];
		end
	end

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q  <= 1'b0;
			sk_v_q <= 1'b0;
		end else if (en) begin
			if (!o_v_q || pix.ready) begin
				o_v_q <= vld_q[NSTG-1];
			end else if (vld_q[NSTG-1]) begin
				sk_v_q <= 1'b1;
			end
		end else if (pix.ready) begin
			sk_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!o_v_q || pix.ready) begin
				o_q <= res;
			end else begin
				sk_q <= res;
			end
		end else if (pix.ready) begin
			o_q <= sk_q;
		end
	end

	assign pix.valid      = o_v_q;
	assign pix.pixel_u    = o_q.u;
	assign pix.pixel_v    = o_q.v;
	assign pix.depth_zero = o_q.dz;
	assign pix.saturated  = o_q.sat;

	// The skid register only ever holds a word behind a waiting output word.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_v_q |-> o_v_q)
		else $error("skid register full while output register is empty");

	// The skid register fills only when the output word was refused.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_v_q) |-> $past(o_v_q && !pix.ready))
		else $error("skid register filled without a refused output word");

	// While the pipe holds, no word moves between stages.
	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline valid bits moved during a hold");

	// A zero depth forces the coordinates to zero and clears the clamp flag.
	a_depth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.depth_zero) |->
			(pix.pixel_u == '0 && pix.pixel_v == '0 && !pix.saturated))
		else $error("zero depth result carries coordinates or a clamp flag");
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// Self-checking testbench for homogeneous_point_projection_core: a directed table, then random
// matrices and points, each pixel word checked against a typed result or a behavioral projection predictor.
// Depends on hpp_pkg, hpp_pnt_if, hpp_pix_if and the core itself.

module testbench;
	import hpp_pkg::*;

	localparam int PHASES       = 12;
	localparam int PHASE_POINTS = 150;
	localparam int HOLD_AFTER   = 500;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 60;

	// Indexes past the last register; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_IDX_W'(CFG_N);
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = CFG_IDX_W'(CFG_N + 1);

	localparam logic [COEF_W-1:0] ONE_Q16     = 32'h0001_0000;
	localparam logic [COEF_W-1:0] NEG_ONE_Q16 = 32'hFFFF_0000;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BUSY} rx_mode_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] x;
		logic signed [COEF_W-1:0] y;
		logic signed [COEF_W-1:0] z;
	} point_t;

	typedef struct {
		bit                   is_write;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
		point_t               pt;
		bit                   typed;
		hpp_res_t             res;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	hpp_pnt_if pts ();
	hpp_pix_if pix ();

	homogeneous_point_projection_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.pts      (pts),
		.pix      (pix)
	);

	// Shadow copy of the projection matrix registers.
	logic [CFG_W-1:0] cam_mat [CFG_N];
	// Pixel words still owed by the core, oldest first.
	hpp_res_t         pixel_q [$];
	stim_row_t        stim_tab [$];

	int unsigned n_points;
	int unsigned n_checked;
	int unsigned n_mismatch;
	int unsigned n_depth_zero;
	int unsigned n_saturated;
	int unsigned n_settings;
	bit          long_hold_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the core hangs.
	initial begin
		#5_000_000;
		$display("Timeout with %0d pixel words outstanding", pixel_q.size());
		$display("== FAIL ==");
		$finish;
	end

	// (num * 2^16) / den on magnitudes, truncated toward zero and clamped to Q16.16.
	function automatic logic [Q_W-1:0] divide_q16(input logic signed [127:0] num,
		input logic signed [127:0] den, output bit clamped);
		logic [127:0]   n_mag;
		logic [127:0]   d_mag;
		logic [127:0]   q;
		logic [Q_W-1:0] limit;
		logic [Q_W-1:0] mag;
		bit             neg;
		neg     = (num < 0) != (den < 0);
		n_mag   = (num < 0) ? -num : num;
		d_mag   = (den < 0) ? -den : den;
		q       = (n_mag << FRAC) / d_mag;
		limit   = neg ? Q_LIMIT_NEG : Q_LIMIT_POS;
		clamped = 1'b0;
		if (q > 128'(limit)) begin
			clamped = 1'b1;
			q       = 128'(limit);
		end
		mag = q[Q_W-1:0];
		return neg ? -mag : mag;
	endfunction

	// Three exact row dot products with (x, y, z, 1), then the perspective divide.
	function automatic hpp_res_t project_point(input point_t p);
		logic signed [127:0] dot [ROWS];
		logic signed [127:0] c0, c1, c2, c3;
		hpp_res_t            r;
		bit                  sat_u, sat_v;
		for (int k = 0; k < ROWS; k++) begin
			c0     = $signed(cam_mat[2*k][31:0]);
			c1     = $signed(cam_mat[2*k][63:32]);
			c2     = $signed(cam_mat[2*k+1][31:0]);
			c3     = $signed(cam_mat[2*k+1][63:32]);
			dot[k] = c0 * p.x + c1 * p.y + c2 * p.z + (c3 <<< FRAC);
		end
		r = '0;
		if (dot[2] == 0) begin
			r.dz = 1'b1;
		end else begin
			r.u   = divide_q16(dot[0], dot[2], sat_u);
			r.v   = divide_q16(dot[1], dot[2], sat_v);
			r.sat = sat_u | sat_v;
		end
		return r;
	endfunction

	function automatic logic [COEF_W-1:0] pick_extreme();
		case ($urandom_range(0, 6))
			0:       return 32'h0000_0000;
			1:       return 32'h0000_0001;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h7FFF_FFFF;
			4:       return 32'h8000_0000;
			5:       return ONE_Q16;
			default: return NEG_ONE_Q16;
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_small();
		return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
	endfunction

	// Matrix coefficient; the depth row leans toward zeros so zero depth shows up.
	function automatic logic [COEF_W-1:0] rand_coef(input bit depth_row);
		if (depth_row && $urandom_range(0, 2) == 0)
			return '0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom();
			4, 5:       return rand_small();
			6:          return '0;
			7:          return ONE_Q16;
			8:          return NEG_ONE_Q16;
			default:    return pick_extreme();
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rand_field();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return $urandom();
			6, 7:             return rand_small();
			8:                return pick_extreme();
			default:          return rand_small() << FRAC;
		endcase
	endfunction

	// Offer one point word and record what the core owes for it once taken.
	task automatic send_point(input point_t p, input bit typed, input hpp_res_t want);
		pts.valid   <= 1'b1;
		pts.world_x <= p.x;
		pts.world_y <= p.y;
		pts.world_z <= p.z;
		@(posedge clk);
		while (!pts.ready)
			@(posedge clk);
		pixel_q.push_back(typed ? want : project_point(p));
		n_points++;
		@(negedge clk);
	endtask

	// Stop offering and wait until every owed pixel word has come back.
	task automatic wait_idle();
		pts.valid <= 1'b0;
		while (pixel_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx < CFG_N)
			cam_mat[idx] = data;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		stim_row_t row;
		row          = '{default: '0};
		row.is_write = 1'b1;
		row.idx      = idx;
		row.data     = data;
		stim_tab.push_back(row);
	endtask

	task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z,
		input bit typed, input logic [31:0] u, input logic [31:0] v, input bit dz, input bit sat);
		stim_row_t row;
		row       = '{default: '0};
		row.pt    = '{x, y, z};
		row.typed = typed;
		row.res   = '{u, v, dz, sat};
		stim_tab.push_back(row);
	endtask

	// Directed table: identity view, zero depth, clamping both ways, spare indexes,
	// then a general matrix whose words go through the predictor.
	task automatic build_table();
		add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1, 32'h0000_0000, 32'h0000_0000, 0, 0);
		add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
		add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
		add_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 1, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0);
		// Depth row all zero: every point lands on zero depth.
		add_write(CFG_ROW2_COLS23, 64'h0);
		add_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 1, 32'h0, 32'h0, 1, 0);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h0, 32'h0, 1, 0);
		// Depth fixed at one LSB, so u and v are scaled up by 2^16.
		add_write(CFG_ROW2_COLS23, 64'h0000_0001_0000_0000);
		add_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1, 32'h7FFF_FFFF, 32'h0, 0, 1);
		add_point(32'hFFFF_0000, 32'h0000_0000, 32'h0000_0000, 1, 32'h8000_0000, 32'h0, 0, 1);
		add_point(32'hFFFF_8000, 32'h0000_0000, 32'h0000_0000, 1, 32'h8000_0000, 32'h0, 0, 0);
		add_point(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 1, 32'h7FFF_FFFF, 32'h0, 0, 1);
		add_point(32'h0000_7FFF, 32'hFFFF_8001, 32'h0000_0000, 1, 32'h7FFF_0000, 32'h8001_0000, 0, 0);
		add_write(CFG_IDX_SPARE_LO, 64'h0);
		add_write(CFG_IDX_SPARE_HI, 64'h0);
		add_point(32'h0001_0000, 32'h0000_0001, 32'h0000_0000, 1, 32'h7FFF_FFFF, 32'h0001_0000, 0, 1);
		// General matrix with a depth of z - 1 plus a small x term.
		add_write(CFG_ROW0_COLS01, 64'h0000_8000_0002_0000);
		add_write(CFG_ROW0_COLS23, 64'h0010_0000_FFFF_0000);
		add_write(CFG_ROW1_COLS01, 64'h0001_0000_FFFF_C000);
		add_write(CFG_ROW1_COLS23, 64'h0000_0000_0000_4000);
		add_write(CFG_ROW2_COLS01, 64'h0000_0000_0000_0100);
		add_write(CFG_ROW2_COLS23, 64'hFFFF_0000_0001_0000);
		add_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0, 0);
		add_point(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 0, '0, '0, 0, 0);
		add_point(32'h0000_0000, 32'h0000_0000, 32'h0010_0000, 0, '0, '0, 0, 0);
		add_point(32'hFFF8_0000, 32'h0000_0000, 32'h0000_0000, 0, '0, '0, 0, 0);
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '0, '0, 0, 0);
		add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, '0, '0, 0, 0);
		add_point(32'h0003_8000, 32'hFFFD_0000, 32'hFFFF_C000, 0, '0, '0, 0, 0);
		add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 0, '0, '0, 0, 0);
	endtask

	// Load one matrix setting; phases 0 to 3 use extreme coefficients, the last the identity view.
	task automatic load_setting(input int phase);
		logic [CFG_W-1:0] word;
		for (int k = 0; k < CFG_N; k++) begin
			case (phase)
				0:          word = 64'hFFFF_FFFF_FFFF_FFFF;
				1:          word = 64'h8000_0000_8000_0000;
				2:          word = 64'h7FFF_FFFF_7FFF_FFFF;
				3:          word = 64'h0;
				PHASES - 1: word = (k == CFG_ROW0_COLS01) ? RST_ROW0_COLS01 :
					(k == CFG_ROW1_COLS01) ? RST_ROW1_COLS01 :
					(k == CFG_ROW2_COLS23) ? RST_ROW2_COLS23 : 64'h0;
				default:    word = {rand_coef(k >= CFG_ROW2_COLS01),
					rand_coef(k >= CFG_ROW2_COLS01)};
			endcase
			write_reg(CFG_IDX_W'(k), word);
		end
		if ($urandom_range(0, 2) == 0)
			write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
				{$urandom(), $urandom()});
		n_settings++;
	endtask

	// Random points in bursts of random length with random gaps.
	task automatic send_random(input int count);
		point_t p;
		int     sent;
		int     burst;
		int     gap;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 40);
			for (int b = 0; b < burst && sent < count; b++) begin
				p = '{rand_field(), rand_field(), rand_field()};
				send_point(p, 1'b0, '0);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				pts.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// Receiver: stretches of differing readiness, plus one long hold that backs up the pipe.
	initial begin
		rx_mode_t    mode;
		int unsigned span;
		pix.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(10, 120);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					RX_OPEN:   pix.ready <= 1'b1;
					RX_COIN:   pix.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: pix.ready <= ($urandom_range(0, 7) == 0);
					default:   pix.ready <= ($urandom_range(0, 3) != 0);
				endcase
			end
			if (!long_hold_done && n_checked >= HOLD_AFTER) begin
				@(negedge clk);
				pix.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold_done = 1'b1;
			end
		end
	end

	// Compare every pixel word taken from the core with the oldest one owed.
	always @(posedge clk) begin
		hpp_res_t got;
		hpp_res_t want;
		if (arst_n && pix.valid && pix.ready) begin
			got = '{pix.pixel_u, pix.pixel_v, pix.depth_zero, pix.saturated};
			if (got.dz)
				n_depth_zero++;
			if (got.sat)
				n_saturated++;
			if (pixel_q.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("%0t: pixel word with none owed: u=%h v=%h dz=%b sat=%b",
						$realtime, got.u, got.v, got.dz, got.sat);
			end else begin
				want = pixel_q.pop_front();
				n_checked++;
				if (got.u !== want.u || got.v !== want.v || got.dz !== want.dz ||
					got.sat !== want.sat) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("%0t: word %0d: expected u=%h v=%h dz=%b sat=%b, got u=%h v=%h dz=%b sat=%b",
							$realtime, n_checked, want.u, want.v, want.dz, want.sat,
							got.u, got.v, got.dz, got.sat);
				end
			end
		end
	end

	// Main sequence: reset, directed table, random phases, drain.
	initial begin
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_idx     = '0;
		cfg_data    = '0;
		pts.valid   = 1'b0;
		pts.world_x = '0;
		pts.world_y = '0;
		pts.world_z = '0;
		cam_mat[CFG_ROW0_COLS01] = RST_ROW0_COLS01;
		cam_mat[CFG_ROW0_COLS23] = RST_ROW0_COLS23;
		cam_mat[CFG_ROW1_COLS01] = RST_ROW1_COLS01;
		cam_mat[CFG_ROW1_COLS23] = RST_ROW1_COLS23;
		cam_mat[CFG_ROW2_COLS01] = RST_ROW2_COLS01;
		cam_mat[CFG_ROW2_COLS23] = RST_ROW2_COLS23;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		build_table();
		foreach (stim_tab[i]) begin
			if (stim_tab[i].is_write) begin
				wait_idle();
				write_reg(stim_tab[i].idx, stim_tab[i].data);
			end else begin
				send_point(stim_tab[i].pt, stim_tab[i].typed, stim_tab[i].res);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			load_setting(ph);
			send_random(PHASE_POINTS);
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Projected %0d points through %0d random or extreme matrices plus the directed table;",
			n_points, n_settings);
		$display("%0d pixel words checked, %0d at zero depth, %0d clamped, %0d mismatches.",
			n_checked, n_depth_zero, n_saturated, n_mismatch);
		if (n_mismatch == 0 && pixel_q.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
